// ===== rtl/csrm_pkg.sv =====
// ----------------------------------------------------------------------------
// csrm_pkg
// Shared types, widths and defaults of the circle scene ray march block.
// ----------------------------------------------------------------------------
package csrm_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int MARCH_STEPS_DEF = 5;
  localparam int FRAC_BITS_DEF   = 16;

  // Widest slot index the input word can address.
  localparam int IDX_W   = 10;
  localparam int IDX_CAP = 1 << IDX_W;

  // Table entry: {active, mask, x, y, radius}.
  localparam int ENT_W = 1 + 8 + 32 + 32 + 31;

  localparam int S_DATA_W = 256;
  localparam int M_DATA_W = 48;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_POINT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic in_wr;
    logic addr_rst;
    logic addr_inc;
    logic q_load;
    logic mul;
    logic point;
    logic rd;
    logic step_upd;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic pipe_busy;
    logic found;
    logic below_eps;
    logic last_step;
    logic out_full;
  } dp_sts_t;

endpackage

// ===== rtl/csrm_ram.sv =====
// ----------------------------------------------------------------------------
// csrm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module csrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/csrm_isqrt.sv =====
// ----------------------------------------------------------------------------
// csrm_isqrt
// Fully pipelined floor square root of a 64-bit value, one result bit per
// stage, with a tag carried alongside.
// ----------------------------------------------------------------------------
module csrm_isqrt #(
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [63:0]      in_val,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [31:0]      out_root,
  output logic [TAG_W-1:0] out_tag,
  output logic             busy
);

  localparam int NST = 32;

  logic [63:0]      n_s    [NST+1];
  logic [63:0]      root_s [NST+1];
  logic [TAG_W-1:0] tag_s  [NST+1];
  logic [NST:0]     v_s;

  assign n_s[0]    = in_val;
  assign root_s[0] = '0;
  assign tag_s[0]  = in_tag;
  assign v_s[0]    = in_valid;

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;

    assign trial = root_s[k] + BIT;
    assign ge    = n_s[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else begin
        v_s[k+1] <= v_s[k];
      end
      n_s[k+1]    <= ge ? n_s[k] - trial : n_s[k];
      root_s[k+1] <= ge ? (root_s[k] >> 1) + BIT : root_s[k] >> 1;
      tag_s[k+1]  <= tag_s[k];
    end
  end

  assign out_valid = v_s[NST];
  assign out_root  = root_s[NST][31:0];
  assign out_tag   = tag_s[NST];
  assign busy      = |v_s[NST:1];

endmodule

// ===== rtl/csrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// csrm_ctrl
// Controller: clearing pass, input acceptance, march step sequencing.
// ----------------------------------------------------------------------------
module csrm_ctrl
  import csrm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_mode,
  output logic    s_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr   = 1'b1;
        cmd.addr_inc = 1'b1;
        if (sts.addr_last) begin
          cmd.addr_rst = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_mode) begin
            cmd.q_load = 1'b1;
            state_next = ST_MUL;
          end else begin
            cmd.in_wr = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_POINT;
      end
      ST_POINT: begin
        cmd.point    = 1'b1;
        cmd.addr_rst = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd       = 1'b1;
        cmd.addr_inc = 1'b1;
        if (sts.addr_last) begin
          cmd.addr_rst = 1'b1;
          state_next   = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!sts.found || sts.below_eps) begin
          state_next = ST_FIN;
        end else begin
          cmd.step_upd = 1'b1;
          state_next   = sts.last_step ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        if (!sts.out_full) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/csrm_datapath.sv =====
// ----------------------------------------------------------------------------
// csrm_datapath
// Circle table, ray point arithmetic, distance scan pipeline and result
// register.
// ----------------------------------------------------------------------------
module csrm_datapath
  import csrm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MARCH_STEPS = MARCH_STEPS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int SCAN_N = (TABLE_DEPTH < IDX_CAP) ? TABLE_DEPTH : IDX_CAP;
  localparam int AW     = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int SW     = (MARCH_STEPS > 1) ? $clog2(MARCH_STEPS + 1) : 1;
  localparam int TAG_W  = 1 + 31 + AW;
  localparam logic signed [33:0] EPS = 34'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  // Input word fields.
  logic [9:0]         f_index;
  logic               f_active;
  logic [7:0]         f_mask;
  logic [31:0]        f_ex, f_ey;
  logic [30:0]        f_rad;
  logic signed [31:0] f_ox, f_oy, f_dx, f_dy;
  logic [7:0]         f_excl;

  assign f_index  = s_tdata[9:0];
  assign f_active = s_tdata[10];
  assign f_mask   = s_tdata[18:11];
  assign f_ex     = s_tdata[50:19];
  assign f_ey     = s_tdata[82:51];
  assign f_rad    = s_tdata[113:83];
  assign f_ox     = s_tdata[145:114];
  assign f_oy     = s_tdata[177:146];
  assign f_dx     = s_tdata[209:178];
  assign f_dy     = s_tdata[241:210];
  assign f_excl   = s_tdata[249:242];

  // Address counter, shared by the clearing pass and the scan.
  logic [AW-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.addr_rst) begin
      addr <= '0;
    end else if (cmd.addr_inc) begin
      addr <= addr + AW'(1);
    end
  end

  // Table memory.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.in_wr) begin
      ram_we    = 32'(f_index) < SCAN_N;
      ram_waddr = f_index[AW-1:0];
      ram_wdata = {f_active, f_mask, f_ex, f_ey, f_rad};
    end
  end

  csrm_ram #(.WIDTH(ENT_W), .DEPTH(SCAN_N)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Query state.
  logic signed [31:0] ox, oy, dx, dy;
  logic [7:0]         excl;
  logic [30:0]        t;
  logic [SW-1:0]      step;
  logic signed [63:0] prod_x, prod_y;
  logic signed [31:0] px, py;

  function automatic logic signed [31:0] sat_point(input logic signed [31:0] o,
                                                   input logic signed [63:0] p);
    logic signed [63:0] s;
    s = 64'(o) + (p >>> FRAC_BITS);
    if (s > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -64'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // Magnitude of a coordinate difference, capped to 31 bits.
  function automatic logic [30:0] cap_diff(input logic signed [31:0] a,
                                           input logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? 33'(-d) : 33'(d);
    return (m > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      ox   <= f_ox;
      oy   <= f_oy;
      dx   <= f_dx;
      dy   <= f_dy;
      excl <= f_excl;
    end
    if (cmd.mul) begin
      prod_x <= dx * $signed({1'b0, t});
      prod_y <= dy * $signed({1'b0, t});
    end
    if (cmd.point) begin
      px <= sat_point(ox, prod_x);
      py <= sat_point(oy, prod_y);
    end
  end

  // Scan pipeline: read, difference, squares, sum, square root, compare.
  logic             v_a, v_b, v_c, v_d;
  logic [AW-1:0]    idx_a, idx_b, idx_c, idx_d;
  logic             q_b, q_c, q_d;
  logic [30:0]      ax, ay, rad_b, rad_c, rad_d;
  logic [61:0]      sqx, sqy;
  logic [62:0]      sq_sum;

  logic             e_active;
  logic [7:0]       e_mask;
  logic [31:0]      e_x, e_y;
  logic [30:0]      e_rad;

  assign {e_active, e_mask, e_x, e_y, e_rad} = ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_a <= cmd.rd;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
    idx_a  <= addr;
    idx_b  <= idx_a;
    q_b    <= e_active && ((e_mask & excl) == 8'd0);
    ax     <= cap_diff(px, e_x);
    ay     <= cap_diff(py, e_y);
    rad_b  <= e_rad;
    idx_c  <= idx_b;
    q_c    <= q_b;
    rad_c  <= rad_b;
    sqx    <= ax * ax;
    sqy    <= ay * ay;
    idx_d  <= idx_c;
    q_d    <= q_c;
    rad_d  <= rad_c;
    sq_sum <= {1'b0, sqx} + {1'b0, sqy};
  end

  logic             r_valid, r_busy;
  logic [31:0]      r_root;
  logic [TAG_W-1:0] r_tag;
  logic             r_q;
  logic [30:0]      r_rad;
  logic [AW-1:0]    r_idx;

  csrm_isqrt #(.TAG_W(TAG_W)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_d),
    .in_val    ({1'b0, sq_sum}),
    .in_tag    ({q_d, rad_d, idx_d}),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_tag   (r_tag),
    .busy      (r_busy)
  );

  assign {r_q, r_rad, r_idx} = r_tag;

  logic signed [33:0] step_dist;
  logic signed [33:0] best;
  logic               found;
  logic [AW-1:0]      hit;
  logic signed [34:0] t_sum;

  assign step_dist = $signed({2'b00, r_root}) - $signed({3'b000, r_rad});
  assign t_sum     = $signed({4'b0000, t}) + $signed({best[33], best});

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.point) begin
      found <= 1'b0;
    end else if (r_valid && r_q && (!found || step_dist < best)) begin
      found <= 1'b1;
    end
    if (r_valid && r_q && (!found || step_dist < best)) begin
      best <= step_dist;
      hit  <= r_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      t    <= '0;
    end else if (cmd.q_load) begin
      step <= '0;
      t    <= '0;
    end else if (cmd.step_upd) begin
      step <= step + SW'(1);
      t    <= (t_sum > 35'sh7FFF_FFFF) ? SAT_MAX[30:0] : t_sum[30:0];
    end
  end

  // Result register.
  logic              out_valid;
  logic [31:0]       out_dist;
  logic [IDX_W-1:0]  out_hit;
  logic              out_nt;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.fin) begin
      out_dist <= found ? {1'b0, t} : SAT_MAX;
      out_hit  <= found ? IDX_W'(hit) : '0;
      out_nt   <= !found;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_nt, out_hit, out_dist};

  assign sts.addr_last = addr == AW'(SCAN_N - 1);
  assign sts.pipe_busy = v_a || v_b || v_c || v_d || r_busy || r_valid;
  assign sts.found     = found;
  assign sts.below_eps = best < EPS;
  assign sts.last_step = step == SW'(MARCH_STEPS - 1);
  assign sts.out_full  = out_valid;

endmodule

// ===== rtl/circle_scene_ray_march.sv =====
// ----------------------------------------------------------------------------
// circle_scene_ray_march
// Table of circles with 2-D sphere-tracing ray queries in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one word per item; s_tuser selects a table
//   write (0) or a ray query (1). A write stores one slot and gives no
//   result word. A query gives exactly one word on the master stream: the
//   final march parameter, the nearest slot and a no-target flag.
//   Each march step reads every slot once from the table memory, one slot
//   per cycle, through the distance pipeline, and a query runs up to
//   MARCH_STEPS steps. The single read port of the table sets that rate.
//   After reset the block clears the active bit of every slot (up to 1024
//   of them), one slot per cycle, with s_tready low.
//   The result stays in its output register until taken; while it waits the
//   block still accepts writes, and a following query runs but holds its
//   result until the register is free.
// ----------------------------------------------------------------------------
module circle_scene_ray_march
  import csrm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MARCH_STEPS = MARCH_STEPS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // entry_index, entry_active, entry_mask, entry_x, entry_y, entry_radius,
  // origin_x, origin_y, dir_x, dir_y, exclude_mask, zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  // mode
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // march_distance, hit_index, no_target, zero pad
  output logic [M_DATA_W-1:0] m_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  csrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_mode   (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csrm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MARCH_STEPS (MARCH_STEPS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  // A missed ray reports the saturated distance and slot zero.
  a_no_target: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[42] |-> m_tdata[31:0] == 32'h7FFF_FFFF && m_tdata[41:32] == 10'd0)
    else $error("no-target word carries a distance or slot");

  // The march parameter of a hit never goes negative.
  a_t_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[42] |-> !m_tdata[31])
    else $error("negative march distance");

  // An accepted query keeps the input side closed on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input accepted during a query");
`endif

endmodule
